/* rtl/dmp_pkg.sv */
// Package for the decrypted message parser: phases, codes and shared types.
// Used by all modules in rtl/.
`timescale 1ns / 1ps
package dmp_pkg;

  localparam int unsigned KEY_BYTES_DEF   = 64;
  localparam int unsigned RIPE_BYTES_DEF  = 20;
  localparam int unsigned LENGTH_BITS_DEF = 32;

  typedef enum logic [4:0] {
    PH_VERSION  = 5'd0,
    PH_STREAM   = 5'd1,
    PH_BEHAV    = 5'd2,
    PH_SIGNKEY  = 5'd3,
    PH_ENCKEY   = 5'd4,
    PH_POWPB    = 5'd5,
    PH_POWEX    = 5'd6,
    PH_RIPE     = 5'd7,
    PH_ENCODING = 5'd8,
    PH_MSGLEN   = 5'd9,
    PH_BODY     = 5'd10,
    PH_ACKLEN   = 5'd11,
    PH_ACK      = 5'd12,
    PH_SIGLEN   = 5'd13,
    PH_SIG      = 5'd14,
    PH_DONE     = 5'd15,
    PH_ERROR    = 5'd16
  } phase_t;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_TRUNC = 3'd2;
  localparam logic [2:0] ST_TRAIL = 3'd3;
  localparam logic [2:0] ST_BIG   = 3'd4;

  localparam logic [2:0] RG_INT  = 3'd0;
  localparam logic [2:0] RG_SKEY = 3'd1;
  localparam logic [2:0] RG_EKEY = 3'd2;
  localparam logic [2:0] RG_RIPE = 3'd3;
  localparam logic [2:0] RG_BODY = 3'd4;
  localparam logic [2:0] RG_ACK  = 3'd5;
  localparam logic [2:0] RG_SIG  = 3'd6;
  localparam logic [2:0] RG_IGN  = 3'd7;

  localparam logic [3:0] FC_VERSION = 4'd0;
  localparam logic [3:0] FC_STREAM  = 4'd1;
  localparam logic [3:0] FC_BEHAV   = 4'd2;
  localparam logic [3:0] FC_POWPB   = 4'd3;
  localparam logic [3:0] FC_POWEX   = 4'd4;
  localparam logic [3:0] FC_ENC     = 4'd5;
  localparam logic [3:0] FC_MSGLEN  = 4'd6;
  localparam logic [3:0] FC_ACKLEN  = 4'd7;
  localparam logic [3:0] FC_SIGNED  = 4'd8;
  localparam logic [3:0] FC_SIGLEN  = 4'd9;

  localparam logic [0:0] CFG_POWPB = 1'd0;
  localparam logic [0:0] CFG_POWEX = 1'd1;

  // Classified byte: everything the back end needs to emit 1..3 results
  typedef struct packed {
    logic [2:0]  region;
    logic [7:0]  data;
    logic        fvalid;
    logic [3:0]  fcode;
    logic [63:0] fvalue;
    logic        pow_ins;   // append default pow per byte and extra results
    logic        ack_ins;   // append signed-length result
    logic [31:0] offset;
    logic [2:0]  status;
  } cls_t;

  // One emitted result
  typedef struct packed {
    logic [2:0]  region;
    logic [7:0]  data;
    logic [3:0]  fcode;
    logic [63:0] fvalue;
    logic        fvalid;
    logic [31:0] offset;
    logic [2:0]  status;
    logic        run_end;
  } res_t;

endpackage

/* rtl/dmp_front.sv */
// Front end: accepts bytes, runs the field parser, produces classified records.
// Depends on dmp_pkg.
`timescale 1ns / 1ps
module dmp_front #(
  parameter int unsigned KEY_BYTES   = dmp_pkg::KEY_BYTES_DEF,
  parameter int unsigned RIPE_BYTES  = dmp_pkg::RIPE_BYTES_DEF,
  parameter int unsigned LENGTH_BITS = dmp_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_final,
  output logic               cls_valid,
  input  logic               cls_ready,
  output dmp_pkg::cls_t      cls_data
);

  dmp_pkg::phase_t phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  vleft_r, vleft_nxt;
  logic [31:0] rleft_r, rleft_nxt;
  logic [31:0] pos_r;
  logic        v3_r, v3_nxt;
  logic [2:0]  err_r, err_nxt;
  dmp_pkg::cls_t c;
  logic        fire;
  logic [63:0] fv;
  logic        fdone;
  logic [31:0] rdec;
  logic [63:0] shifted;

  assign in_ready  = cls_ready;
  assign cls_valid = in_valid;
  assign fire      = in_valid & cls_ready;
  assign cls_data  = c;

  // Classify the byte and compute the next parser state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    vleft_nxt = vleft_r;
    rleft_nxt = rleft_r;
    v3_nxt    = v3_r;
    err_nxt   = err_r;
    fdone     = 1'b0;
    fv        = '0;
    rdec      = rleft_r - 32'd1;
    shifted   = {acc_r[55:0], in_byte};
    c         = '0;
    c.data    = in_byte;
    c.offset  = pos_r;
    c.region  = dmp_pkg::RG_INT;
    case (phase_r)
      dmp_pkg::PH_ERROR: c.region = dmp_pkg::RG_IGN;
      dmp_pkg::PH_DONE: begin
        c.region  = dmp_pkg::RG_IGN;
        err_nxt   = dmp_pkg::ST_TRAIL;
        phase_nxt = dmp_pkg::PH_ERROR;
      end
      dmp_pkg::PH_BEHAV: begin
        acc_nxt   = shifted;
        vleft_nxt = vleft_r - 4'd1;
        if (vleft_nxt == 4'd0) begin
          fdone = 1'b1;
          fv    = {32'd0, shifted[31:0]};
        end
      end
      dmp_pkg::PH_SIGNKEY, dmp_pkg::PH_ENCKEY, dmp_pkg::PH_RIPE,
      dmp_pkg::PH_BODY, dmp_pkg::PH_ACK, dmp_pkg::PH_SIG: begin
        case (phase_r)
          dmp_pkg::PH_SIGNKEY: c.region = dmp_pkg::RG_SKEY;
          dmp_pkg::PH_ENCKEY:  c.region = dmp_pkg::RG_EKEY;
          dmp_pkg::PH_RIPE:    c.region = dmp_pkg::RG_RIPE;
          dmp_pkg::PH_BODY:    c.region = dmp_pkg::RG_BODY;
          dmp_pkg::PH_ACK:     c.region = dmp_pkg::RG_ACK;
          default:             c.region = dmp_pkg::RG_SIG;
        endcase
        rleft_nxt = rdec;
        if (rdec == 32'd0) begin
          case (phase_r)
            dmp_pkg::PH_SIGNKEY: begin
              rleft_nxt = 32'(KEY_BYTES);
              phase_nxt = dmp_pkg::PH_ENCKEY;
            end
            dmp_pkg::PH_ENCKEY: begin
              if (v3_r) begin
                phase_nxt = dmp_pkg::PH_POWPB;
              end else begin
                c.pow_ins = 1'b1;
                rleft_nxt = 32'(RIPE_BYTES);
                phase_nxt = dmp_pkg::PH_RIPE;
              end
            end
            dmp_pkg::PH_RIPE: phase_nxt = dmp_pkg::PH_ENCODING;
            dmp_pkg::PH_BODY: phase_nxt = dmp_pkg::PH_ACKLEN;
            dmp_pkg::PH_ACK: begin
              c.ack_ins = 1'b1;
              phase_nxt = dmp_pkg::PH_SIGLEN;
            end
            default: phase_nxt = dmp_pkg::PH_DONE;
          endcase
        end
      end
      default: begin
        if (vleft_r == 4'd0) begin
          if (in_byte < 8'hfd) begin
            fdone = 1'b1;
            fv    = {56'd0, in_byte};
          end else begin
            vleft_nxt = (in_byte == 8'hfd) ? 4'd2 : (in_byte == 8'hfe) ? 4'd4 : 4'd8;
            acc_nxt   = '0;
          end
        end else begin
          acc_nxt   = shifted;
          vleft_nxt = vleft_r - 4'd1;
          if (vleft_nxt == 4'd0) begin
            fdone = 1'b1;
            fv    = shifted;
          end
        end
      end
    endcase

    // Field completion: report it and advance the phase
    if (fdone) begin
      c.fvalid  = 1'b1;
      c.fvalue  = fv;
      acc_nxt   = '0;
      vleft_nxt = 4'd0;
      case (phase_r)
        dmp_pkg::PH_VERSION: begin
          c.fcode   = dmp_pkg::FC_VERSION;
          v3_nxt    = (fv >= 64'd3);
          phase_nxt = dmp_pkg::PH_STREAM;
        end
        dmp_pkg::PH_STREAM: begin
          c.fcode   = dmp_pkg::FC_STREAM;
          vleft_nxt = 4'd4;
          phase_nxt = dmp_pkg::PH_BEHAV;
        end
        dmp_pkg::PH_BEHAV: begin
          c.fcode   = dmp_pkg::FC_BEHAV;
          rleft_nxt = 32'(KEY_BYTES);
          phase_nxt = dmp_pkg::PH_SIGNKEY;
        end
        dmp_pkg::PH_POWPB: begin
          c.fcode   = dmp_pkg::FC_POWPB;
          phase_nxt = dmp_pkg::PH_POWEX;
        end
        dmp_pkg::PH_POWEX: begin
          c.fcode   = dmp_pkg::FC_POWEX;
          rleft_nxt = 32'(RIPE_BYTES);
          phase_nxt = dmp_pkg::PH_RIPE;
        end
        dmp_pkg::PH_ENCODING: begin
          c.fcode   = dmp_pkg::FC_ENC;
          phase_nxt = dmp_pkg::PH_MSGLEN;
        end
        default: begin
          if (phase_r == dmp_pkg::PH_MSGLEN) c.fcode = dmp_pkg::FC_MSGLEN;
          else if (phase_r == dmp_pkg::PH_ACKLEN) c.fcode = dmp_pkg::FC_ACKLEN;
          else c.fcode = dmp_pkg::FC_SIGLEN;
          if ((fv >> LENGTH_BITS) != 64'd0) begin
            err_nxt   = dmp_pkg::ST_BIG;
            phase_nxt = dmp_pkg::PH_ERROR;
          end else if (fv == 64'd0) begin
            if (phase_r == dmp_pkg::PH_MSGLEN) phase_nxt = dmp_pkg::PH_ACKLEN;
            else if (phase_r == dmp_pkg::PH_ACKLEN) begin
              phase_nxt = dmp_pkg::PH_SIGLEN;
              c.ack_ins = 1'b1;
            end else phase_nxt = dmp_pkg::PH_DONE;
          end else begin
            rleft_nxt = fv[31:0];
            if (phase_r == dmp_pkg::PH_MSGLEN) phase_nxt = dmp_pkg::PH_BODY;
            else if (phase_r == dmp_pkg::PH_ACKLEN) phase_nxt = dmp_pkg::PH_ACK;
            else phase_nxt = dmp_pkg::PH_SIG;
          end
        end
      endcase
    end

    if (err_nxt != dmp_pkg::ST_RUN) c.status = err_nxt;
    else if (in_final) c.status = (phase_nxt == dmp_pkg::PH_DONE) ?
                                  dmp_pkg::ST_OK : dmp_pkg::ST_TRUNC;
    else c.status = dmp_pkg::ST_RUN;
  end

  // Parser state; the final byte restarts the message
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dmp_pkg::PH_VERSION;
      acc_r   <= '0;
      vleft_r <= '0;
      rleft_r <= '0;
      pos_r   <= '0;
      v3_r    <= 1'b0;
      err_r   <= '0;
    end else if (fire) begin
      if (in_final) begin
        phase_r <= dmp_pkg::PH_VERSION;
        acc_r   <= '0;
        vleft_r <= '0;
        rleft_r <= '0;
        pos_r   <= '0;
        v3_r    <= 1'b0;
        err_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        vleft_r <= vleft_nxt;
        rleft_r <= rleft_nxt;
        pos_r   <= pos_r + 32'd1;
        v3_r    <= v3_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

/* rtl/dmp_queue.sv */
// Two-entry queue of classified records between front and back ends.
// Depends on dmp_pkg.
`timescale 1ns / 1ps
module dmp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  dmp_pkg::cls_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output dmp_pkg::cls_t rd_data
);

  dmp_pkg::cls_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid & wr_ready;
  assign rd       = rd_valid & rd_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

/* rtl/dmp_back.sv */
// Back end: expands each classified record into one to three results.
// Depends on dmp_pkg.
`timescale 1ns / 1ps
module dmp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [31:0]   pow_pb,
  input  logic [31:0]   pow_ex,
  input  logic          rec_valid,
  output logic          rec_ready,
  input  dmp_pkg::cls_t rec,
  output logic          res_valid,
  input  logic          res_ready,
  output dmp_pkg::res_t res
);

  logic [1:0] idx_r;
  logic [1:0] last;
  logic       take;
  dmp_pkg::res_t cur;
  dmp_pkg::res_t out_r;
  logic       oval_r;
  logic       ospace;

  assign last   = rec.pow_ins ? 2'd2 : rec.ack_ins ? 2'd1 : 2'd0;
  assign ospace = !oval_r || res_ready;
  assign take   = rec_valid && ospace;
  assign rec_ready = take && (idx_r == last);
  assign res_valid = oval_r;
  assign res       = out_r;

  // Build the result for the current slot of the record
  always_comb begin
    cur         = '0;
    cur.offset  = rec.offset;
    cur.status  = rec.status;
    cur.run_end = (idx_r == last);
    cur.region  = dmp_pkg::RG_INT;
    if (idx_r == 2'd0) begin
      cur.region = rec.region;
      cur.data   = rec.data;
      cur.fcode  = rec.fcode;
      cur.fvalue = rec.fvalue;
      cur.fvalid = rec.fvalid;
    end else if (rec.pow_ins) begin
      cur.fvalid = 1'b1;
      cur.fcode  = (idx_r == 2'd1) ? dmp_pkg::FC_POWPB : dmp_pkg::FC_POWEX;
      cur.fvalue = (idx_r == 2'd1) ? {32'd0, pow_pb} : {32'd0, pow_ex};
    end else begin
      cur.fvalid = 1'b1;
      cur.fcode  = dmp_pkg::FC_SIGNED;
      cur.fvalue = {32'd0, rec.offset} + 64'd1;
    end
  end

  // Output register and slot counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      if (ospace) oval_r <= take;
      if (take) idx_r <= (idx_r == last) ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_r <= cur;
  end

endmodule

/* rtl/decrypted_message_parser_top.sv */
// Top level of the decrypted message parser: config registers, front, queue, back.
// Depends on dmp_pkg, dmp_front, dmp_queue, dmp_back.
`timescale 1ns / 1ps
// Channel   Dir  Transaction
// in        in   one message byte, tlast on final byte
// out       out  one result: region, byte, field, offset, status; tlast ends a byte's run
// cfg       in   write of a default proof-of-work register
//
// One byte a cycle enters the front parser; the back end emits one result a
// cycle, so a byte with inserted results yields two or three results.
// Rate drops below one byte a cycle only for inserted results or a stalled output.
// rst_n is synchronous; it clears parser, queue and output control and sets both
// registers to 1000. Either side may stall; the two-entry queue decouples them.
module decrypted_message_parser_top #(
  parameter int unsigned KEY_BYTES   = dmp_pkg::KEY_BYTES_DEF,
  parameter int unsigned RIPE_BYTES  = dmp_pkg::RIPE_BYTES_DEF,
  parameter int unsigned LENGTH_BITS = dmp_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // region, byte_out, field_code, field_value,
                                   // field_valid, byte_offset, status, zero fill
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  logic [31:0] pow_pb_r, pow_ex_r;
  logic        f_valid, f_ready, q_valid, q_ready;
  dmp_pkg::cls_t f_data, q_data;
  dmp_pkg::res_t r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow_pb_r <= 32'd1000;
      pow_ex_r <= 32'd1000;
    end else if (cfg_we) begin
      if (cfg_index == dmp_pkg::CFG_POWPB) pow_pb_r <= cfg_wdata;
      if (cfg_index == dmp_pkg::CFG_POWEX) pow_ex_r <= cfg_wdata;
    end
  end

  dmp_front #(.KEY_BYTES(KEY_BYTES), .RIPE_BYTES(RIPE_BYTES),
              .LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_byte(in_tdata), .in_final(in_tlast),
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
  );

  dmp_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  dmp_back u_back (
    .clk, .rst_n, .pow_pb(pow_pb_r), .pow_ex(pow_ex_r),
    .rec_valid(q_valid), .rec_ready(q_ready), .rec(q_data),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(r)
  );

  assign out_tdata = {5'd0, r.status, r.offset, r.fvalid, r.fvalue, r.fcode,
                      r.data, r.region};
  assign out_tlast = r.run_end;

  // Inserted signed-length results carry zero data
  a_ins_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.fvalid && r.fcode == dmp_pkg::FC_SIGNED |-> r.data == 8'd0)
    else $error("signed-length result with nonzero byte");

  // Hold the result while the output is stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // A field result never lies in a payload region
  a_field_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.fvalid |-> r.region == dmp_pkg::RG_INT)
    else $error("field reported outside integer region");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for decrypted_message_parser_top.
// Depends on dmp_pkg and the RTL under rtl/; a scoreboard class predicts every result.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned KEYB  = dmp_pkg::KEY_BYTES_DEF;
  localparam int unsigned RIPEB = dmp_pkg::RIPE_BYTES_DEF;
  localparam int unsigned LENB  = dmp_pkg::LENGTH_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Message parser model plus the queue of results it predicts
  class parse_scoreboard;
    logic [31:0]     pow_pb;
    logic [31:0]     pow_ex;
    dmp_pkg::phase_t phase;
    logic [63:0]     accum;
    logic [3:0]      vleft;
    logic [31:0]     rleft;
    logic [31:0]     pos;
    bit              v3;
    logic [2:0]      err;
    dmp_pkg::res_t   step_res[$];
    dmp_pkg::res_t   expected_res[$];
    int              fails;

    function new();
      pow_pb = 32'd1000;
      pow_ex = 32'd1000;
      fails  = 0;
      clear();
    endfunction

    function void clear();
      phase = dmp_pkg::PH_VERSION;
      accum = '0;
      vleft = '0;
      rleft = '0;
      pos   = '0;
      v3    = 1'b0;
      err   = dmp_pkg::ST_RUN;
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] val);
      if (idx == dmp_pkg::CFG_POWPB) pow_pb = val;
      else pow_ex = val;
    endfunction

    function void add(logic [2:0] rg, logic [7:0] d, logic [3:0] c, logic [63:0] v, logic vl);
      dmp_pkg::res_t r;
      r = '0;
      r.region = rg;
      r.data   = d;
      r.fcode  = c;
      r.fvalue = v;
      r.fvalid = vl;
      if (step_res.size() < 3) step_res.push_back(r);
    endfunction

    function logic [3:0] code_of(dmp_pkg::phase_t p);
      case (p)
        dmp_pkg::PH_STREAM:   return dmp_pkg::FC_STREAM;
        dmp_pkg::PH_BEHAV:    return dmp_pkg::FC_BEHAV;
        dmp_pkg::PH_POWPB:    return dmp_pkg::FC_POWPB;
        dmp_pkg::PH_POWEX:    return dmp_pkg::FC_POWEX;
        dmp_pkg::PH_ENCODING: return dmp_pkg::FC_ENC;
        dmp_pkg::PH_MSGLEN:   return dmp_pkg::FC_MSGLEN;
        dmp_pkg::PH_ACKLEN:   return dmp_pkg::FC_ACKLEN;
        dmp_pkg::PH_SIGLEN:   return dmp_pkg::FC_SIGLEN;
        default:              return dmp_pkg::FC_VERSION;
      endcase
    endfunction

    function logic [2:0] region_of(dmp_pkg::phase_t p);
      case (p)
        dmp_pkg::PH_SIGNKEY: return dmp_pkg::RG_SKEY;
        dmp_pkg::PH_ENCKEY:  return dmp_pkg::RG_EKEY;
        dmp_pkg::PH_RIPE:    return dmp_pkg::RG_RIPE;
        dmp_pkg::PH_BODY:    return dmp_pkg::RG_BODY;
        dmp_pkg::PH_ACK:     return dmp_pkg::RG_ACK;
        dmp_pkg::PH_SIG:     return dmp_pkg::RG_SIG;
        default:             return dmp_pkg::RG_INT;
      endcase
    endfunction

    function void ack_done();
      add(dmp_pkg::RG_INT, 8'd0, dmp_pkg::FC_SIGNED, {32'd0, pos} + 64'd1, 1'b1);
      phase = dmp_pkg::PH_SIGLEN;
    endfunction

    function void take_length(logic [63:0] v, dmp_pkg::phase_t body_ph,
                              dmp_pkg::phase_t empty_ph);
      if ((v >> LENB) != 0) begin
        err = dmp_pkg::ST_BIG;
        phase = dmp_pkg::PH_ERROR;
      end else if (v == 0) begin
        phase = empty_ph;
      end else begin
        rleft = v[31:0];
        phase = body_ph;
      end
    endfunction

    function void finish_field(logic [63:0] v);
      step_res[0].fcode  = code_of(phase);
      step_res[0].fvalue = v;
      step_res[0].fvalid = 1'b1;
      accum = '0;
      vleft = '0;
      case (phase)
        dmp_pkg::PH_VERSION: begin
          v3 = (v >= 64'd3);
          phase = dmp_pkg::PH_STREAM;
        end
        dmp_pkg::PH_STREAM: begin
          vleft = 4'd4;
          phase = dmp_pkg::PH_BEHAV;
        end
        dmp_pkg::PH_BEHAV: begin
          rleft = KEYB;
          phase = dmp_pkg::PH_SIGNKEY;
        end
        dmp_pkg::PH_POWPB: phase = dmp_pkg::PH_POWEX;
        dmp_pkg::PH_POWEX: begin
          rleft = RIPEB;
          phase = dmp_pkg::PH_RIPE;
        end
        dmp_pkg::PH_ENCODING: phase = dmp_pkg::PH_MSGLEN;
        dmp_pkg::PH_MSGLEN: take_length(v, dmp_pkg::PH_BODY, dmp_pkg::PH_ACKLEN);
        dmp_pkg::PH_ACKLEN: begin
          take_length(v, dmp_pkg::PH_ACK, dmp_pkg::PH_SIGLEN);
          if (phase == dmp_pkg::PH_SIGLEN) ack_done();
        end
        default: take_length(v, dmp_pkg::PH_SIG, dmp_pkg::PH_DONE);
      endcase
    endfunction

    function void region_done();
      case (phase)
        dmp_pkg::PH_SIGNKEY: begin
          rleft = KEYB;
          phase = dmp_pkg::PH_ENCKEY;
        end
        dmp_pkg::PH_ENCKEY: begin
          if (v3) begin
            phase = dmp_pkg::PH_POWPB;
          end else begin
            add(dmp_pkg::RG_INT, 8'd0, dmp_pkg::FC_POWPB, {32'd0, pow_pb}, 1'b1);
            add(dmp_pkg::RG_INT, 8'd0, dmp_pkg::FC_POWEX, {32'd0, pow_ex}, 1'b1);
            rleft = RIPEB;
            phase = dmp_pkg::PH_RIPE;
          end
        end
        dmp_pkg::PH_RIPE: phase = dmp_pkg::PH_ENCODING;
        dmp_pkg::PH_BODY: phase = dmp_pkg::PH_ACKLEN;
        dmp_pkg::PH_ACK:  ack_done();
        default: phase = dmp_pkg::PH_DONE;
      endcase
    endfunction

    // Predict the results of one accepted input transaction
    function void note_byte(logic [7:0] b, logic fin);
      logic [31:0] off;
      logic [2:0]  st;
      off = pos;
      step_res.delete();
      case (phase)
        dmp_pkg::PH_ERROR: add(dmp_pkg::RG_IGN, b, 4'd0, 64'd0, 1'b0);
        dmp_pkg::PH_DONE: begin
          add(dmp_pkg::RG_IGN, b, 4'd0, 64'd0, 1'b0);
          err = dmp_pkg::ST_TRAIL;
          phase = dmp_pkg::PH_ERROR;
        end
        dmp_pkg::PH_BEHAV: begin
          add(dmp_pkg::RG_INT, b, 4'd0, 64'd0, 1'b0);
          accum = (accum << 8) | b;
          vleft = vleft - 4'd1;
          if (vleft == 0) finish_field(accum & 64'hffff_ffff);
        end
        dmp_pkg::PH_SIGNKEY, dmp_pkg::PH_ENCKEY, dmp_pkg::PH_RIPE,
        dmp_pkg::PH_BODY, dmp_pkg::PH_ACK, dmp_pkg::PH_SIG: begin
          add(region_of(phase), b, 4'd0, 64'd0, 1'b0);
          rleft = rleft - 32'd1;
          if (rleft == 0) region_done();
        end
        default: begin
          add(dmp_pkg::RG_INT, b, 4'd0, 64'd0, 1'b0);
          if (vleft == 0) begin
            if (b < 8'hfd) finish_field({56'd0, b});
            else begin
              vleft = (b == 8'hfd) ? 4'd2 : (b == 8'hfe) ? 4'd4 : 4'd8;
              accum = '0;
            end
          end else begin
            accum = (accum << 8) | b;
            vleft = vleft - 4'd1;
            if (vleft == 0) finish_field(accum);
          end
        end
      endcase
      pos = pos + 32'd1;
      if (err != dmp_pkg::ST_RUN) st = err;
      else if (fin) st = (phase == dmp_pkg::PH_DONE) ? dmp_pkg::ST_OK : dmp_pkg::ST_TRUNC;
      else st = dmp_pkg::ST_RUN;
      foreach (step_res[k]) begin
        step_res[k].offset  = off;
        step_res[k].status  = st;
        step_res[k].run_end = (k == step_res.size() - 1);
        expected_res.push_back(step_res[k]);
      end
      if (fin) clear();
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
        fails++;
      end
    endfunction

    // Compare one output transaction with the oldest prediction
    function void check_result(logic [119:0] d, logic last);
      dmp_pkg::res_t e;
      if (expected_res.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0h", $time, d);
        fails++;
        return;
      end
      e = expected_res.pop_front();
      cmp("region", e.region, d[2:0]);
      cmp("byte_out", e.data, d[10:3]);
      cmp("field_code", e.fcode, d[14:11]);
      cmp("field_value", e.fvalue, d[78:15]);
      cmp("field_valid", e.fvalid, d[79]);
      cmp("byte_offset", e.offset, d[111:80]);
      cmp("status", e.status, d[114:112]);
      cmp("run_end", e.run_end, last);
      cmp("zero_fill", 64'd0, d[119:115]);
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  logic         out_tlast;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  parse_scoreboard sb;
  bit idle_on;
  int cycles;
  int stall_left;
  int bytes_sent;

  decrypted_message_parser_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Observe transactions and register writes at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 12);
    end
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Drive one byte and hold it until the transaction completes
  task automatic send_byte(logic [7:0] b, logic fin);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_msg(ref logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Write one register once every prediction has been met
  task automatic write_cfg(logic [0:0] idx, logic [31:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_res.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Append a var_int, in the shortest form or a wider one at random
  task automatic push_var(ref logic [7:0] q[$], input logic [63:0] v);
    int nb;
    if (v < 64'hfd && $urandom_range(0, 3) != 0) nb = 0;
    else if (v < 64'h1_0000 && $urandom_range(0, 1) == 0) nb = 2;
    else if (v < 64'h1_0000_0000 && $urandom_range(0, 1) == 0) nb = 4;
    else nb = 8;
    if (nb == 0) begin
      q.push_back(v[7:0]);
    end else begin
      q.push_back(nb == 2 ? 8'hfd : nb == 4 ? 8'hfe : 8'hff);
      for (int i = nb - 1; i >= 0; i--) q.push_back(v[8*i +: 8]);
    end
  endtask

  task automatic push_raw(ref logic [7:0] q[$], input int n);
    repeat (n) q.push_back($urandom_range(0, 255));
  endtask

  task automatic push_length(ref logic [7:0] q[$], input bit huge, input int n);
    if (huge) push_var(q, {$urandom_range(1, 32'hffff_ffff), 32'd0} | $urandom);
    else begin
      push_var(q, n);
      push_raw(q, n);
    end
  endtask

  // Build one message: well-formed, truncated, with trailing bytes, oversized or noise
  task automatic build_msg(ref logic [7:0] q[$]);
    int kind;
    int big_at;
    logic [63:0] ver;
    q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      push_raw(q, $urandom_range(1, 20));
      return;
    end
    big_at = (kind == 8) ? $urandom_range(0, 2) : 3;
    case ($urandom_range(0, 6))
      0: ver = {$urandom, $urandom};
      1: ver = $urandom;
      default: ver = $urandom_range(0, 5);
    endcase
    push_var(q, ver);
    push_var(q, $urandom_range(0, 1) ? {32'd0, $urandom} : {$urandom, $urandom});
    push_raw(q, 4 + 2 * KEYB);
    if (ver >= 3) begin
      push_var(q, {$urandom, $urandom});
      push_var(q, $urandom_range(0, 300));
    end
    push_raw(q, RIPEB);
    push_var(q, $urandom_range(0, 1) ? {$urandom, $urandom} : $urandom_range(0, 3));
    push_length(q, big_at == 0, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
    if (big_at == 0) begin
      push_raw(q, $urandom_range(0, 3));
      return;
    end
    push_length(q, big_at == 1, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 4));
    if (big_at == 1) begin
      push_raw(q, $urandom_range(0, 3));
      return;
    end
    push_length(q, big_at == 2, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 5));
    if (big_at == 2) begin
      push_raw(q, $urandom_range(0, 3));
      return;
    end
    if (kind == 6) begin
      q = q[0 : $urandom_range(0, q.size() - 2)];
    end else if (kind == 7) begin
      push_raw(q, $urandom_range(1, 3));
    end
  endtask

  initial begin
    logic [7:0] msg[$];
    sb = new();
    idle_on = 1'b1;
    cycles = 0;
    bytes_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = dmp_pkg::CFG_POWPB;
    cfg_wdata = 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short directed messages: each var_int prefix form, ends at once
    send_byte(8'hfc, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hfd, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b1);
    send_byte(8'hfe, 1'b0);
    repeat (4) send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    repeat (8) send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hfd, 1'b1);

    // Random messages, each under a new register setting
    while (bytes_sent < 360) begin
      write_cfg(dmp_pkg::CFG_POWPB, pick_reg());
      write_cfg(dmp_pkg::CFG_POWEX, pick_reg());
      if (bytes_sent > 280) idle_on = 1'b0;
      build_msg(msg);
      send_msg(msg);
    end
    in_tvalid <= 1'b0;

    while (sb.expected_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.expected_res.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
